FILE: design/tvs_pkg.sv
// Shared types and constants for the triangular variate sampler.
package tvs_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned UBits = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    DistTriangular = 2'd0,
    DistNormal = 2'd1,
    DistUniform = 2'd2,
    DistUnused = 2'd3
  } dist_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDistMode = 2'd0,
    RegMinTime = 2'd1,
    RegMaxTime = 2'd2,
    RegModeTime = 2'd3
  } cfg_reg_e;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic [1:0] kind;     // 0 zero result, 1 error, 2 lower branch, 3 upper branch
    logic [63:0] radicand;
    logic [TimeW-1:0] base;
  } job_t;

  localparam logic [1:0] KindZero = 2'd0;
  localparam logic [1:0] KindError = 2'd1;
  localparam logic [1:0] KindLower = 2'd2;
  localparam logic [1:0] KindUpper = 2'd3;
endpackage

FILE: design/tvs_front.sv
// Front part: pipelined classification and radicand products.
module tvs_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [tvs_pkg::UBits-1:0] u_i,
  input  logic [1:0] dist_mode_i,
  input  logic [tvs_pkg::TimeW-1:0] a_i,
  input  logic [tvs_pkg::TimeW-1:0] b_i,
  input  logic [tvs_pkg::TimeW-1:0] c_i,
  input  logic advance_i,
  output logic out_valid_o,
  output tvs_pkg::job_t job_o
);
  localparam int unsigned W = tvs_pkg::TimeW;
  localparam int unsigned UB = tvs_pkg::UBits;

  // Stage 1: differences, classification and branch test.
  logic v1_q;
  logic [1:0] kind1_q;
  logic [W-1:0] d1_q, dx_q, base1_q;
  logic [UB:0] f1_q;
  logic [W-1:0] d1, d2, d3;
  logic [W+UB-1:0] lhs, rhs;
  logic bad, lower;
  logic [1:0] kind1_d;

  always_comb begin
    d1 = b_i - a_i;
    d2 = c_i - a_i;
    d3 = b_i - c_i;
    bad = (b_i <= a_i) || (c_i < a_i) || (c_i > b_i);
    lhs = {{W{1'b0}}, u_i} * {{UB{1'b0}}, d1};
    rhs = {d2, {UB{1'b0}}};
    lower = lhs < rhs;
    if (dist_mode_i != tvs_pkg::DistTriangular) begin
      kind1_d = tvs_pkg::KindZero;
    end else if (bad) begin
      kind1_d = tvs_pkg::KindError;
    end else if (lower) begin
      kind1_d = tvs_pkg::KindLower;
    end else begin
      kind1_d = tvs_pkg::KindUpper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      kind1_q <= kind1_d;
      d1_q <= d1;
      dx_q <= lower ? d2 : d3;
      f1_q <= lower ? {1'b0, u_i} : ((UB+1)'(1) << UB) - {1'b0, u_i};
      base1_q <= (kind1_d == tvs_pkg::KindUpper) ? b_i :
                 (kind1_d == tvs_pkg::KindZero) ? '0 : a_i;
    end
  end

  // Stage 2: product of the two spans (one 32x32 multiply).
  logic v2_q;
  logic [1:0] kind2_q;
  logic [2*W-1:0] p2_q;
  logic [UB:0] f2_q;
  logic [W-1:0] base2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      kind2_q <= kind1_q;
      p2_q <= {{W{1'b0}}, d1_q} * {{W{1'b0}}, dx_q};
      f2_q <= f1_q;
      base2_q <= base1_q;
    end
  end

  // Stage 3: scale by the fraction, split into two 17x32 partial products.
  logic v3_q;
  logic [1:0] kind3_q;
  logic [W+UB:0] ph3_q, pl3_q;
  logic [W-1:0] base3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (advance_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      kind3_q <= kind2_q;
      ph3_q <= {{W{1'b0}}, f2_q} * {{(UB+1){1'b0}}, p2_q[2*W-1:W]};
      pl3_q <= {{W{1'b0}}, f2_q} * {{(UB+1){1'b0}}, p2_q[W-1:0]};
      base3_q <= base2_q;
    end
  end

  // Stage 4: sum of the partial products.
  logic [95:0] sum4;
  always_comb begin
    sum4 = ({47'd0, ph3_q} << (W - UB)) + ({47'd0, pl3_q} >> UB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance_i) begin
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      job_o.kind <= kind3_q;
      job_o.radicand <= sum4[63:0];
      job_o.base <= base3_q;
    end
  end
endmodule

FILE: design/tvs_queue.sv
// Short queue between the front and back parts.
module tvs_queue #(
  parameter int unsigned DEPTH = tvs_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tvs_pkg::job_t data_i,
  input  logic pop_i,
  output logic not_empty_o,
  output logic room_o,
  output tvs_pkg::job_t data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  tvs_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i) rd_q <= bump(rd_q);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o = mem_q[rd_q];
  assign not_empty_o = cnt_q != '0;
  assign room_o = cnt_q != (AW+1)'(DEPTH);

  overflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o || pop_i) else $error("queue overflow");
  underflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o) else $error("queue underflow");
  count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH)) else $error("queue count out of range");
endmodule

FILE: design/tvs_back.sv
// Back part: pipelined integer square root, two result bits per stage.
module tvs_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  tvs_pkg::job_t job_i,
  input  logic advance_i,
  output logic out_valid_o,
  output logic [tvs_pkg::TimeW-1:0] sample_o,
  output logic err_o
);
  localparam int unsigned W = tvs_pkg::TimeW;
  localparam int unsigned St = 16;

  logic v_q [St+1];
  logic [1:0] kind_q [St+1];
  logic [W-1:0] base_q [St+1];
  logic [63:0] rem_q [St+1];
  logic [W-1:0] root_q [St+1];
  logic [63:0] x_q [St+1];

  always_comb begin
    v_q[0] = in_valid_i;
    kind_q[0] = job_i.kind;
    base_q[0] = job_i.base;
    rem_q[0] = '0;
    root_q[0] = '0;
    x_q[0] = job_i.radicand;
  end

  // Each stage brings down four radicand bits and settles two root bits.
  for (genvar s = 0; s < St; s++) begin : g_st
    logic [65:0] r;
    logic [65:0] t;
    logic [W-1:0] q;
    logic [65:0] r2;
    logic [65:0] t2;
    logic [W-1:0] q2;
    always_comb begin
      r = {rem_q[s], x_q[s][63:62]};
      t = {32'd0, root_q[s], 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {root_q[s][W-2:0], 1'b1};
      end else begin
        q = {root_q[s][W-2:0], 1'b0};
      end
      r2 = {r[63:0], x_q[s][61:60]};
      t2 = {32'd0, q, 2'b01};
      if (r2 >= t2) begin
        r2 = r2 - t2;
        q2 = {q[W-2:0], 1'b1};
      end else begin
        q2 = {q[W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (advance_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        kind_q[s+1] <= kind_q[s];
        base_q[s+1] <= base_q[s];
        rem_q[s+1] <= r2[63:0];
        root_q[s+1] <= q2;
        x_q[s+1] <= {x_q[s][59:0], 4'd0};
      end
    end
  end

  // Output register applies the root to the base.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance_i) begin
      out_valid_o <= v_q[St];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      err_o <= kind_q[St] == tvs_pkg::KindError;
      case (kind_q[St])
        tvs_pkg::KindLower: sample_o <= base_q[St] + root_q[St];
        tvs_pkg::KindUpper: sample_o <= base_q[St] - root_q[St];
        default: sample_o <= base_q[St];
      endcase
    end
  end
endmodule

FILE: design/triangular_variate_sampler.sv
// Top level of the triangular variate sampler.
// Takes one uniform word per cycle while the input is not stalled and returns
// one sample per cycle while the output is not stalled: a triangular sample,
// the minimum time flagged by config_error_o for bad bounds, or zero in the
// other modes. An accepted word passes 4 front stages (classification, 32x32
// span product, split fraction scaling, sum), waits in the 4-entry queue,
// then passes a 16-stage square-root pipeline and an output register. The
// bounds use the fixed-point format of tvs_pkg::FracBits; the arithmetic does
// not depend on it. The input stalls only when the queue is full and the front
// holds a word for it; the back stalls only while its output word is held.
module triangular_variate_sampler (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tvs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tvs_pkg::TimeW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [tvs_pkg::UBits-1:0] uniform_frac_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [tvs_pkg::TimeW-1:0] sample_time_o,
  output logic config_error_o
);
  localparam int unsigned W = tvs_pkg::TimeW;

  logic [1:0] mode_q;
  logic [W-1:0] a_q, b_q, c_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tvs_pkg::DistTriangular;
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tvs_pkg::RegDistMode: mode_q <= cfg_data_i[1:0];
        tvs_pkg::RegMinTime: a_q <= cfg_data_i;
        tvs_pkg::RegMaxTime: b_q <= cfg_data_i;
        tvs_pkg::RegModeTime: c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front advances unless its output word finds the queue full.
  logic f_valid, f_adv, q_ne, q_room, q_push, q_pop, b_adv;
  tvs_pkg::job_t f_job, q_job;

  assign f_adv = q_room || !f_valid;
  assign in_stall_o = !f_adv;
  assign q_push = f_valid && f_adv;
  assign b_adv = !(out_valid_o && out_stall_i);
  assign q_pop = q_ne && b_adv;

  tvs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i),
    .u_i(uniform_frac_i),
    .dist_mode_i(mode_q),
    .a_i(a_q), .b_i(b_q), .c_i(c_q),
    .advance_i(f_adv),
    .out_valid_o(f_valid),
    .job_o(f_job)
  );

  tvs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(f_job),
    .pop_i(q_pop),
    .not_empty_o(q_ne), .room_o(q_room), .data_o(q_job)
  );

  tvs_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_pop),
    .job_i(q_job),
    .advance_i(b_adv),
    .out_valid_o(out_valid_o),
    .sample_o(sample_time_o),
    .err_o(config_error_o)
  );

  hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result word dropped");
  stall_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> f_valid && !q_room) else $error("spurious input stall");
  stable_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_time_o) && $stable(config_error_o))
    else $error("stalled result word changed");
endmodule
